/* rtl/core/mwat_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mwat_pkg
// Shared types and constants of the memory window access tracer.
// ----------------------------------------------------------------------------
package mwat_pkg;

    localparam int THREADS_DEF = 32;
    localparam int SLOTS_DEF   = 1024;

    typedef enum logic [3:0] {
        OP_SELECT    = 4'd0,
        OP_ALLOC_REQ = 4'd1,
        OP_ALLOC_RET = 4'd2,
        OP_START     = 4'd3,
        OP_STOP      = 4'd4,
        OP_FREE      = 4'd5,
        OP_READ      = 4'd6,
        OP_WRITE     = 4'd7,
        OP_CREATE    = 4'd8,
        OP_DESTROY   = 4'd9,
        OP_QUERY     = 4'd10
    } t_op;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_BAD_THREAD = 3'd1,
        ST_FULL       = 3'd2,
        ST_ALLOC_NULL = 3'd3,
        ST_ZERO_SIZE  = 3'd4,
        ST_NO_BLOCK   = 3'd5,
        ST_FREED      = 3'd6
    } t_status;

    typedef enum logic [1:0] {
        SEL_NONE = 2'd0,
        SEL_SIZE = 2'd1,
        SEL_ADDR = 2'd2
    } t_sel;

    localparam logic [1:0] KIND_CREATE  = 2'd0;
    localparam logic [1:0] KIND_DESTROY = 2'd1;
    localparam logic [1:0] KIND_READ    = 2'd2;
    localparam logic [1:0] KIND_WRITE   = 2'd3;

    typedef struct packed {
        logic [3:0]  op;
        logic [7:0]  thread;
        logic [63:0] address;
        logic [63:0] length;
        logic [31:0] time_stamp;
    } t_item_in;

    typedef struct packed {
        logic        record_valid;
        logic [1:0]  record_kind;
        logic [4:0]  record_thread;
        logic [9:0]  record_slot;
        logic [31:0] record_time;
        logic [31:0] record_size;
        logic [63:0] record_offset;
        logic [2:0]  status;
        logic [10:0] thread_fill;
        logic [31:0] thread_overflow;
        logic        tracing_on;
    } t_item_out;

    typedef struct packed {
        logic    in_win;
        t_status status;
        logic    tracing_nx;
    } t_win_res;

endpackage
`default_nettype wire

/* rtl/core/mwat_win.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mwat_win
// Window capture sequence, tracing state and the access window filter.
// ----------------------------------------------------------------------------
module mwat_win
    import mwat_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_adv,
    input  wire logic [3:0]  i_op,
    input  wire logic [63:0] i_address,
    input  wire logic [63:0] i_length,
    output t_win_res         o_win,
    output logic [63:0]      o_offset
);

    t_sel        r_phase, n_phase;
    logic [63:0] r_start, n_start;
    logic [63:0] r_size, n_size;
    logic        r_tr, n_tr;
    t_status     status;

    assign o_offset = i_address - r_start;

    always_comb begin
        n_phase = r_phase;
        n_start = r_start;
        n_size  = r_size;
        n_tr    = r_tr;
        status  = ST_OK;
        case (i_op)
            OP_SELECT: begin
                n_phase = SEL_SIZE;
            end
            OP_ALLOC_REQ: begin
                if (r_phase == SEL_SIZE) begin
                    n_phase = SEL_ADDR;
                    n_size  = i_length;
                end
            end
            OP_ALLOC_RET: begin
                if (r_phase == SEL_ADDR) begin
                    n_phase = SEL_NONE;
                    n_start = i_address;
                    if (i_address == 64'd0) begin
                        status = ST_ALLOC_NULL;
                    end else if (r_size == 64'd0) begin
                        status = ST_ZERO_SIZE;
                    end
                end
            end
            OP_START: begin
                if (!r_tr) begin
                    if (r_start == 64'd0 || r_size == 64'd0) begin
                        status = ST_NO_BLOCK;
                    end else begin
                        n_tr = 1'b1;
                    end
                end
            end
            OP_STOP: begin
                if (r_tr) begin
                    n_start = '0;
                    n_size  = '0;
                    n_tr    = 1'b0;
                end
            end
            OP_FREE: begin
                if (r_tr && i_address == r_start) begin
                    n_start = '0;
                    n_size  = '0;
                    n_tr    = 1'b0;
                    status  = ST_FREED;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        o_win.in_win     = r_tr && (r_size != 64'd0) && (i_length != 64'd0)
                           && (o_offset < r_size);
        o_win.status     = status;
        o_win.tracing_nx = n_tr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= SEL_NONE;
            r_start <= '0;
            r_size  <= '0;
            r_tr    <= 1'b0;
        end else if (i_adv) begin
            r_phase <= n_phase;
            r_start <= n_start;
            r_size  <= n_size;
            r_tr    <= n_tr;
        end
    end

endmodule
`default_nettype wire

/* rtl/core/mwat_cnt.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mwat_cnt
// Per-thread fill and overflow counters: memory with registered read,
// per-entry valid bits and write-to-read bypass.
// ----------------------------------------------------------------------------
module mwat_cnt
    import mwat_pkg::*;
#(
    parameter int THREADS          = THREADS_DEF,
    parameter int SLOTS_PER_THREAD = SLOTS_DEF,
    localparam int TIW = (THREADS > 1) ? $clog2(THREADS) : 1,
    localparam int FW  = $clog2(SLOTS_PER_THREAD + 1)
)
(
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_rd_en,
    input  wire logic [7:0]    i_rd_thread,
    input  wire logic          i_wr_en,
    input  wire logic [7:0]    i_wr_thread,
    input  wire logic [FW-1:0] i_wr_fill,
    input  wire logic [31:0]   i_wr_ovf,
    output logic [FW-1:0]      o_fill,
    output logic [31:0]        o_ovf
);

    logic [FW-1:0]    r_fill_mem [THREADS];
    logic [31:0]      r_ovf_mem  [THREADS];
    logic [THREADS-1:0] r_vld;
    logic [FW-1:0]    r_rd_fill;
    logic [31:0]      r_rd_ovf;
    logic [TIW-1:0]   rd_idx;
    logic [TIW-1:0]   wr_idx;

    assign rd_idx = i_rd_thread[TIW-1:0];
    assign wr_idx = i_wr_thread[TIW-1:0];
    assign o_fill = r_rd_fill;
    assign o_ovf  = r_rd_ovf;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_fill_mem[wr_idx] <= i_wr_fill;
            r_ovf_mem[wr_idx]  <= i_wr_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_wr_en) begin
            r_vld[wr_idx] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            if (i_wr_en && wr_idx == rd_idx) begin
                r_rd_fill <= i_wr_fill;
                r_rd_ovf  <= i_wr_ovf;
            end else if (r_vld[rd_idx]) begin
                r_rd_fill <= r_fill_mem[rd_idx];
                r_rd_ovf  <= r_ovf_mem[rd_idx];
            end else begin
                r_rd_fill <= '0;
                r_rd_ovf  <= '0;
            end
        end
    end

endmodule
`default_nettype wire

/* rtl/core/memory_window_access_tracer.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// memory_window_access_tracer
// Traces reads and writes inside a captured memory window and thread events
// into per-thread record slots, with saturating overflow counts.
// ----------------------------------------------------------------------------
//  channel  | valid        | stall        | payload
//  input    | i_item_valid | o_item_stall | i_item (t_item_in)
//  result   | o_res_valid  | i_res_stall  | o_res  (t_item_out)
//
//  One transaction per cycle unless stalled; items pass r_a, then r_o.
//  The counter memory is read at acceptance and written when the item moves
//  to the result register; a bypass covers back-to-back items of one thread.
//  Reset is synchronous; counter entries are cleared at once by valid bits.
//  A stalled result holds; the input stage keeps accepting while it has room.
// ----------------------------------------------------------------------------
module memory_window_access_tracer
    import mwat_pkg::*;
#(
    parameter int THREADS          = THREADS_DEF,
    parameter int SLOTS_PER_THREAD = SLOTS_DEF
)
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_item_valid,
    output logic          o_item_stall,
    input  wire t_item_in i_item,
    output logic          o_res_valid,
    input  wire logic     i_res_stall,
    output t_item_out     o_res
);

    localparam int FW = $clog2(SLOTS_PER_THREAD + 1);

    logic             r_a_vld;
    t_item_in         r_a;
    logic             r_o_vld;
    t_item_out        r_o;
    t_item_out        n_o;

    logic             adv;
    logic             acc;
    t_win_res         win;
    logic [63:0]      offset;
    logic [FW-1:0]    fill;
    logic [31:0]      ovf;
    logic [FW+10:0]   fill_x;
    logic             is_rw;
    logic             is_th;
    logic             rec_req;
    logic             bad;
    logic             full;
    logic             wr_en;
    logic [FW-1:0]    wr_fill;
    logic [31:0]      wr_ovf;

    assign adv          = r_a_vld && (!r_o_vld || !i_res_stall);
    assign o_item_stall = r_a_vld && !adv;
    assign acc          = i_item_valid && !o_item_stall;
    assign o_res_valid  = r_o_vld;
    assign o_res        = r_o;

    mwat_win u_win (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_adv     (adv),
        .i_op      (r_a.op),
        .i_address (r_a.address),
        .i_length  (r_a.length),
        .o_win     (win),
        .o_offset  (offset)
    );

    mwat_cnt #(
        .THREADS          (THREADS),
        .SLOTS_PER_THREAD (SLOTS_PER_THREAD)
    ) u_cnt (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rd_en     (acc),
        .i_rd_thread (i_item.thread),
        .i_wr_en     (wr_en),
        .i_wr_thread (r_a.thread),
        .i_wr_fill   (wr_fill),
        .i_wr_ovf    (wr_ovf),
        .o_fill      (fill),
        .o_ovf       (ovf)
    );

    assign fill_x  = (FW + 11)'(fill);
    assign is_rw   = (r_a.op == OP_READ) || (r_a.op == OP_WRITE);
    assign is_th   = (r_a.op == OP_CREATE) || (r_a.op == OP_DESTROY);
    assign rec_req = (is_rw && win.in_win) || is_th;
    assign bad     = {1'b0, r_a.thread} >= 9'(THREADS);
    assign full    = fill >= FW'(SLOTS_PER_THREAD);
    assign wr_en   = adv && rec_req && !bad;
    assign wr_fill = full ? fill : FW'(fill + 1'b1);
    assign wr_ovf  = (full && ovf != 32'hFFFF_FFFF) ? ovf + 32'd1 : ovf;

    always_comb begin
        n_o            = '0;
        n_o.status     = win.status;
        n_o.tracing_on = win.tracing_nx;
        if (rec_req) begin
            if (bad) begin
                n_o.status = ST_BAD_THREAD;
            end else if (full) begin
                n_o.status = ST_FULL;
            end else begin
                n_o.record_valid  = 1'b1;
                n_o.record_thread = r_a.thread[4:0];
                n_o.record_slot   = fill_x[9:0];
                n_o.record_time   = r_a.time_stamp;
                case (r_a.op)
                    OP_READ:    n_o.record_kind = KIND_READ;
                    OP_WRITE:   n_o.record_kind = KIND_WRITE;
                    OP_CREATE:  n_o.record_kind = KIND_CREATE;
                    default:    n_o.record_kind = KIND_DESTROY;
                endcase
                if (is_rw) begin
                    n_o.record_size   = (r_a.length[63:32] != 32'd0) ? 32'hFFFF_FFFF
                                                                     : r_a.length[31:0];
                    n_o.record_offset = offset;
                end
            end
        end
        if (r_a.op == OP_QUERY) begin
            if (bad) begin
                n_o.status = ST_BAD_THREAD;
            end else begin
                n_o.thread_fill     = fill_x[10:0];
                n_o.thread_overflow = ovf;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_o_vld <= 1'b0;
        end else begin
            if (acc) begin
                r_a_vld <= 1'b1;
            end else if (adv) begin
                r_a_vld <= 1'b0;
            end
            if (adv) begin
                r_o_vld <= 1'b1;
            end else if (!i_res_stall) begin
                r_o_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_a <= i_item;
        end
        if (adv) begin
            r_o <= n_o;
        end
    end

`ifndef NO_ASSERTIONS
    a_accept_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && r_a_vld) |-> adv)
        else $error("input stage overwritten before it moved on");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_a_vld && !bad) |-> (fill <= FW'(SLOTS_PER_THREAD)))
        else $error("fill count beyond slot count");

    a_access_needs_tracing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_vld && r_o.record_valid &&
         (r_o.record_kind == KIND_READ || r_o.record_kind == KIND_WRITE))
        |-> r_o.tracing_on)
        else $error("access record while tracing off");
`endif

endmodule
`default_nettype wire
